/* rtl/pd_pkg.sv */
`timescale 1ns / 1ps
// pd_pkg: shared constants and types for the polyline densifier.
// No dependencies; imported by pd_front, pd_back and polyline_densify.
package pd_pkg;

	localparam int DEF_COORD_WIDTH    = 32;
	localparam int DEF_MAX_SEG_POINTS = 63;

	localparam int DIST_W = 31;  // insert_distance width
	localparam int REC_W  = 24;  // record id width
	localparam int CNT_W  = 7;   // raw segment count, saturates at 127
	localparam int N_W    = 6;   // points per segment, up to 63

	localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(25600);

	// configuration register indexes
	localparam logic REG_ENABLE   = 1'b0;
	localparam logic REG_DISTANCE = 1'b1;

	typedef enum logic {
		CMD_POINT,  // emit the current vertex once
		CMD_SEG     // densify the segment prev -> current
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_ROOT,
		ST_CNT,
		ST_DIV,
		ST_EMIT,
		ST_END
	} bk_state_t;

endpackage

/* rtl/pd_queue.sv */
`timescale 1ns / 1ps
// pd_queue: two-entry command queue between front and back.
// Generic, no package dependency.
module pd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign rdata = mem_q[rptr_q];

endmodule

/* rtl/pd_front.sv */
`timescale 1ns / 1ps
// pd_front: accepts vertices, tracks the previous vertex and classifies
// each vertex into a queue command. Depends on pd_pkg.
module pd_front
	import pd_pkg::*;
#(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	localparam int CMD_W = 4 * COORD_WIDTH + REC_W + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_WIDTH-1:0] vertex_x,
	input  logic [COORD_WIDTH-1:0] vertex_y,
	input  logic                   part_start,
	input  logic                   part_end,
	input  logic [REC_W-1:0]       record_id,
	input  logic                   densify_enable,
	input  logic [DIST_W-1:0]      insert_distance,
	input  logic                   q_full,
	output logic                   q_push,
	output logic [CMD_W-1:0]       q_cmd
);

	logic [COORD_WIDTH-1:0] prev_x_q;
	logic [COORD_WIDTH-1:0] prev_y_q;
	logic                   have_prev_q;
	logic                   accept;
	logic                   need;
	cmd_kind_t              kind;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (!densify_enable || insert_distance == '0) begin
			need = 1'b1;
			kind = CMD_POINT;
		end else if (part_start || !have_prev_q) begin
			need = part_end;
			kind = CMD_POINT;
		end else begin
			need = 1'b1;
			kind = CMD_SEG;
		end
	end

	assign q_push = accept && need;
	assign q_cmd  = {part_end, record_id, vertex_y, vertex_x, prev_y_q, prev_x_q, kind};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			prev_x_q    <= vertex_x;
			prev_y_q    <= vertex_y;
			have_prev_q <= !part_end;
		end
	end

endmodule

/* rtl/pd_back.sv */
`timescale 1ns / 1ps
// pd_back: per-segment point count (serial square, square root, short
// divide) and point generation into the output register. Depends on pd_pkg.
module pd_back
	import pd_pkg::*;
#(
	parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
	parameter int MAX_SEG_POINTS = DEF_MAX_SEG_POINTS,
	localparam int CMD_W = 4 * COORD_WIDTH + REC_W + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  logic [CMD_W-1:0]       cmd_data,
	output logic                   cmd_pop,
	input  logic [DIST_W-1:0]      insert_distance,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_WIDTH-1:0] point_x,
	output logic [COORD_WIDTH-1:0] point_y,
	output logic [REC_W-1:0]       point_record,
	output logic                   run_last,
	output logic                   count_clamped
);

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int SW   = $clog2(DW + 8);
	localparam int CMPW = (DW > DIST_W + CNT_W) ? DW : DIST_W + CNT_W;
	localparam logic [N_W-1:0] MAX_N = N_W'(MAX_SEG_POINTS);

	// command fields
	cmd_kind_t         c_kind;
	logic [CW-1:0]     c_px, c_py, c_cx, c_cy;
	logic [REC_W-1:0]  c_rec;
	logic              c_end;
	logic signed [DW-1:0] c_dx, c_dy;

	assign c_kind = cmd_kind_t'(cmd_data[0]);
	assign c_px   = cmd_data[CW:1];
	assign c_py   = cmd_data[2*CW:CW+1];
	assign c_cx   = cmd_data[3*CW:2*CW+1];
	assign c_cy   = cmd_data[4*CW:3*CW+1];
	assign c_rec  = cmd_data[4*CW+REC_W:4*CW+1];
	assign c_end  = cmd_data[4*CW+REC_W+1];
	assign c_dx   = DW'($signed(c_cx)) - DW'($signed(c_px));
	assign c_dy   = DW'($signed(c_cy)) - DW'($signed(c_py));

	bk_state_t state_q, state_d;

	logic [CW-1:0]    px_q, py_q, cx_q, cy_q;
	logic [REC_W-1:0] rec_q;
	logic             end_q, negx_q, negy_q;
	logic [SW-1:0]    step_q;
	// serial multiply
	logic [2*DW-1:0]  mcx_q, mcy_q, acc_q;
	logic [DW-1:0]    mpx_q, mpy_q;
	// square root
	logic [DW+1:0]    rrem_q;
	logic [DW-1:0]    root_q;
	// count divide
	logic [CMPW-1:0]  crem_q;
	logic [CNT_W-1:0] q_q;
	// step divide, quotient shifts into num
	logic [DW-1:0]    numx_q, numy_q;
	logic [N_W-1:0]   remx_q, remy_q;
	// interpolation accumulators
	logic [DW-1:0]    accx_q, accy_q;
	logic [N_W+1:0]   arx_q, ary_q;
	logic [N_W-1:0]   j_q;
	// output register
	logic             out_valid_q;
	logic [CW-1:0]    out_x_q, out_y_q;
	logic [REC_W-1:0] out_rec_q;
	logic             out_last_q, out_clamp_q;

	logic             can_load, load_out, clamp;
	logic [N_W-1:0]   n_c;
	logic             last_j, ovf;
	logic [DW+3:0]    rsh, rtrial;
	logic [CMPW-1:0]  dsh;
	logic [N_W:0]     shx, shy;
	logic [N_W+1:0]   sumx, sumy, two_n;
	logic [DW-1:0]    ptx, pty;

	assign can_load = !out_valid_q || out_ready;
	assign clamp    = q_q >= CNT_W'(MAX_SEG_POINTS);
	assign n_c      = clamp ? MAX_N : q_q[N_W-1:0] + N_W'(1);
	assign last_j   = j_q == n_c - N_W'(1);
	assign ovf      = CMPW'(root_q) >= (CMPW'(insert_distance) << CNT_W);
	assign dsh      = CMPW'(insert_distance) << step_q[2:0];
	assign rsh      = {rrem_q, acc_q[2*DW-1:2*DW-2]};
	assign rtrial   = {2'b00, root_q, 2'b01};
	assign shx      = {remx_q, numx_q[DW-1]};
	assign shy      = {remy_q, numy_q[DW-1]};
	assign two_n    = {1'b0, n_c, 1'b0};
	assign sumx     = arx_q + {remx_q, 1'b0};
	assign sumy     = ary_q + {remy_q, 1'b0};
	assign ptx      = DW'($signed(px_q)) + (negx_q ? -accx_q : accx_q);
	assign pty      = DW'($signed(py_q)) + (negy_q ? -accy_q : accy_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) state_d = (c_kind == CMD_SEG) ? ST_SQR : ST_END;
			ST_SQR:  if (step_q == SW'(DW - 1)) state_d = ST_ROOT;
			ST_ROOT: if (step_q == SW'(DW - 1)) state_d = ST_CNT;
			ST_CNT:  if ((step_q == SW'(CNT_W) && ovf) || step_q == '0) state_d = ST_DIV;
			ST_DIV:  if (step_q == '0) state_d = ST_EMIT;
			ST_EMIT: if (can_load && last_j) state_d = end_q ? ST_END : ST_IDLE;
			ST_END:  if (can_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_pop  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd_pop = cmd_valid;
			ST_EMIT, ST_END: load_out = can_load;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q   <= c_px;
				py_q   <= c_py;
				cx_q   <= c_cx;
				cy_q   <= c_cy;
				rec_q  <= c_rec;
				end_q  <= c_end;
				negx_q <= c_dx[DW-1];
				negy_q <= c_dy[DW-1];
				mpx_q  <= c_dx[DW-1] ? -c_dx : c_dx;
				mpy_q  <= c_dy[DW-1] ? -c_dy : c_dy;
				numx_q <= c_dx[DW-1] ? -c_dx : c_dx;
				numy_q <= c_dy[DW-1] ? -c_dy : c_dy;
				mcx_q  <= (2*DW)'(c_dx[DW-1] ? -c_dx : c_dx);
				mcy_q  <= (2*DW)'(c_dy[DW-1] ? -c_dy : c_dy);
				acc_q  <= '0;
				remx_q <= '0;
				remy_q <= '0;
				q_q    <= '0;
				step_q <= '0;
			end
			ST_SQR: begin
				acc_q <= acc_q + (mpx_q[0] ? mcx_q : '0) + (mpy_q[0] ? mcy_q : '0);
				mcx_q <= mcx_q << 1;
				mcy_q <= mcy_q << 1;
				mpx_q <= mpx_q >> 1;
				mpy_q <= mpy_q >> 1;
				rrem_q <= '0;
				root_q <= '0;
				step_q <= (step_q == SW'(DW - 1)) ? '0 : step_q + SW'(1);
			end
			ST_ROOT: begin
				acc_q <= acc_q << 2;
				if (rsh >= rtrial) begin
					rrem_q <= (DW+2)'(rsh - rtrial);
					root_q <= {root_q[DW-2:0], 1'b1};
				end else begin
					rrem_q <= rsh[DW+1:0];
					root_q <= {root_q[DW-2:0], 1'b0};
				end
				step_q <= (step_q == SW'(DW - 1)) ? SW'(CNT_W) : step_q + SW'(1);
			end
			ST_CNT: begin
				if (step_q == SW'(CNT_W)) begin
					crem_q <= CMPW'(root_q);
					q_q    <= ovf ? '1 : '0;
					step_q <= ovf ? SW'(DW - 1) : SW'(CNT_W - 1);
				end else begin
					if (crem_q >= dsh) begin
						crem_q          <= crem_q - dsh;
						q_q[step_q[2:0]] <= 1'b1;
					end
					step_q <= (step_q == '0) ? SW'(DW - 1) : step_q - SW'(1);
				end
			end
			ST_DIV: begin
				if (shx >= {1'b0, n_c}) begin
					remx_q <= N_W'(shx - {1'b0, n_c});
					numx_q <= {numx_q[DW-2:0], 1'b1};
				end else begin
					remx_q <= shx[N_W-1:0];
					numx_q <= {numx_q[DW-2:0], 1'b0};
				end
				if (shy >= {1'b0, n_c}) begin
					remy_q <= N_W'(shy - {1'b0, n_c});
					numy_q <= {numy_q[DW-2:0], 1'b1};
				end else begin
					remy_q <= shy[N_W-1:0];
					numy_q <= {numy_q[DW-2:0], 1'b0};
				end
				accx_q <= '0;
				accy_q <= '0;
				arx_q  <= (N_W+2)'(n_c);
				ary_q  <= (N_W+2)'(n_c);
				j_q    <= '0;
				step_q <= step_q - SW'(1);
			end
			ST_EMIT: begin
				if (can_load) begin
					j_q <= j_q + N_W'(1);
					if (sumx >= two_n) begin
						arx_q  <= sumx - two_n;
						accx_q <= accx_q + numx_q + DW'(1);
					end else begin
						arx_q  <= sumx;
						accx_q <= accx_q + numx_q;
					end
					if (sumy >= two_n) begin
						ary_q  <= sumy - two_n;
						accy_q <= accy_q + numy_q + DW'(1);
					end else begin
						ary_q  <= sumy;
						accy_q <= accy_q + numy_q;
					end
				end
			end
			default: ;
		endcase

		if (load_out) begin
			out_rec_q   <= rec_q;
			out_clamp_q <= clamp;
			if (state_q == ST_EMIT) begin
				out_x_q    <= ptx[CW-1:0];
				out_y_q    <= pty[CW-1:0];
				out_last_q <= last_j && !end_q;
			end else begin
				out_x_q    <= cx_q;
				out_y_q    <= cy_q;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign point_x       = out_x_q;
	assign point_y       = out_y_q;
	assign point_record  = out_rec_q;
	assign run_last      = out_last_q;
	assign count_clamped = out_clamp_q;

`ifndef ASSERT_OFF
	a_j_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> j_q < n_c)
		else $error("point index past segment count");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (arx_q < two_n && ary_q < two_n))
		else $error("interpolation remainder out of range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q == ST_SQR || state_q == ST_END))
		else $error("popped command not started");
	a_point_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && c_kind == CMD_POINT) |=> !clamp)
		else $error("clamp flag on single vertex");
`endif

endmodule

/* rtl/polyline_densify.sv */
`timescale 1ns / 1ps
// polyline_densify: top level; configuration registers, stream packing,
// front/queue/back hookup. Depends on pd_pkg, pd_front, pd_queue, pd_back.
//
// Usage:
//  s_axis: one vertex per beat. tdata = {record_id, vertex_y, vertex_x}
//   (x lowest), tuser = {part_end, part_start}.
//  m_axis: point beats. tdata = {point_record, point_y, point_x},
//   tlast = last point caused by one vertex, tuser = count_clamped.
//  cfg: cfg_valid/cfg_ready with cfg_index (0 = densify_enable,
//   1 = insert_distance) and cfg_data; always ready. Write only while idle.
// Timing: a copied vertex passes through the queue and the back end's end
//  state into the output register. A densified segment runs through the serial
//  squarer, the bit-serial square root, the count divider and the step divider,
//  then emits one point per cycle while m_axis is ready: n, plus one more at a
//  part end. The back end handles one segment at a time; a two-entry queue
//  lets the front keep accepting vertices meanwhile.
// Reset clears the previous vertex, the queue, the back end and output valid;
//  configuration returns to copy mode with distance 100.0.
// A stalled m_axis holds the output register; the back end waits, the queue
//  fills, then s_axis_tready drops.
module polyline_densify
	import pd_pkg::*;
#(
	parameter int MAX_SEG_POINTS = DEF_MAX_SEG_POINTS,
	parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
	localparam int DATA_W = ((2 * COORD_WIDTH + REC_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,   // vertex_x, vertex_y, record_id, pad
	input  logic [1:0]        s_axis_tuser,   // part_start, part_end
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,   // point_x, point_y, point_record, pad
	output logic              m_axis_tlast,   // run_last
	output logic [0:0]        m_axis_tuser,   // count_clamped
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [DIST_W-1:0] cfg_data
);

	localparam int CW    = COORD_WIDTH;
	localparam int CMD_W = 4 * CW + REC_W + 2;
	localparam int PAD_W = DATA_W - 2 * CW - REC_W;

	logic              enable_q;
	logic [DIST_W-1:0] distance_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			distance_q <= DIST_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_DISTANCE: distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic             q_full, q_push, q_pop, q_valid;
	logic [CMD_W-1:0] q_wdata, q_rdata;

	pd_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.vertex_x       (s_axis_tdata[CW-1:0]),
		.vertex_y       (s_axis_tdata[2*CW-1:CW]),
		.part_start     (s_axis_tuser[0]),
		.part_end       (s_axis_tuser[1]),
		.record_id      (s_axis_tdata[2*CW+REC_W-1:2*CW]),
		.densify_enable (enable_q),
		.insert_distance(distance_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_cmd          (q_wdata)
	);

	pd_queue #(
		.W(CMD_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_rdata)
	);

	logic [CW-1:0]    pt_x, pt_y;
	logic [REC_W-1:0] pt_rec;

	pd_back #(
		.COORD_WIDTH   (COORD_WIDTH),
		.MAX_SEG_POINTS(MAX_SEG_POINTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (q_valid),
		.cmd_data       (q_rdata),
		.cmd_pop        (q_pop),
		.insert_distance(distance_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.point_x        (pt_x),
		.point_y        (pt_y),
		.point_record   (pt_rec),
		.run_last       (m_axis_tlast),
		.count_clamped  (m_axis_tuser[0])
	);

	// zero padding up to whole bytes
	assign m_axis_tdata = {{PAD_W{1'b0}}, pt_rec, pt_y, pt_x};

endmodule

/* dv/tb_polyline_densify.sv */
`timescale 1ns / 1ps
// tb_polyline_densify: self-checking bench for the polyline densifier.
// Depends on pd_pkg and the polyline_densify RTL; needs nothing else.
module tb_polyline_densify;
	import pd_pkg::*;

	localparam int DATA_W  = 88;
	localparam int SEG_MAX = 63;
	localparam int SETTLE  = 200;   // cycles for a segment still in the back end
	localparam int WD_LIMIT = 5000; // cycles with no beat on any channel

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [23:0] rec;
		logic        last;
		logic        clamp;
	} point_t;

	typedef enum logic { ROW_CFG, ROW_VTX } row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        idx;
		logic [30:0] val;
		logic [31:0] x;
		logic [31:0] y;
		logic        ps;
		logic        pe;
		logic [23:0] rec;
		bit          lit;   // expectation typed in: a single copied point
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;   // vertex_x, vertex_y, record_id, pad
	logic [1:0] s_axis_tuser = '0;          // part_start, part_end
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;        // point_x, point_y, point_record, pad
	logic m_axis_tlast;                     // run_last
	logic [0:0] m_axis_tuser;               // count_clamped
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [DIST_W-1:0] cfg_data = '0;

	polyline_densify i_dut (.*);

	always #4 clk = ~clk;

	// predictor state: a copy of the block's configuration and previous vertex
	logic        mdl_en;
	logic [30:0] mdl_dist;
	logic [31:0] mdl_px, mdl_py;
	bit          mdl_have;

	point_t pt_q[$];      // points of the vertex just predicted
	point_t point_q[$];   // points still due on m_axis
	row_t   rows[$];
	int     errors = 0;
	int     n_points = 0;
	int     n_clamped = 0;
	int     n_vtx = 0;
	bit     quiet = 1'b0;   // no idling on either side

	task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
		errors++;
		$display("MISMATCH %s: got %h want %h (point %0d)", what, got, want, n_points);
	endtask

	// rounded step j/n along one axis, half away from zero
	function automatic logic [31:0] step_pt(input longint a, input longint d,
			input int j, input int n);
		longint unsigned m, q;
		m = (d < 0 ? -d : d) * j;
		q = (2 * m + n) / (2 * n);
		return (d < 0) ? 32'(a - longint'(q)) : 32'(a + longint'(q));
	endfunction

	// expected points of one vertex; leaves them in pt_q and updates prev
	task automatic densify_vertex(input logic [31:0] vx, input logic [31:0] vy,
			input logic ps, input logic pe, input logic [23:0] rec);
		longint ax, ay, dx, dy;
		logic [127:0] len2, kd;
		int q, n;
		logic clamp;
		pt_q.delete();
		clamp = 1'b0;
		if (!mdl_en || mdl_dist == 0) begin
			pt_q.push_back('{vx, vy, rec, 1'b0, 1'b0});
		end else if (ps || !mdl_have) begin
			if (pe) pt_q.push_back('{vx, vy, rec, 1'b0, 1'b0});
		end else begin
			ax = longint'($signed(mdl_px));
			ay = longint'($signed(mdl_py));
			dx = longint'($signed(vx)) - ax;
			dy = longint'($signed(vy)) - ay;
			len2 = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
				+ 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy);
			q = 0;
			for (int j = 1; j <= SEG_MAX; j++) begin
				kd = 128'(j) * 128'(mdl_dist);
				if (kd * kd <= len2) q = j;
				else break;
			end
			if (q >= SEG_MAX) begin
				n = SEG_MAX;
				clamp = 1'b1;
			end else begin
				n = q + 1;
			end
			pt_q.push_back('{mdl_px, mdl_py, rec, 1'b0, clamp});
			for (int j = 1; j < n; j++)
				pt_q.push_back('{step_pt(ax, dx, j, n), step_pt(ay, dy, j, n),
					rec, 1'b0, clamp});
			if (pe) pt_q.push_back('{vx, vy, rec, 1'b0, clamp});
		end
		if (pt_q.size() > 0) pt_q[$].last = 1'b1;
		if (clamp) n_clamped++;
		mdl_have = !pe;
		mdl_px = vx;
		mdl_py = vy;
	endtask

	task automatic add_cfg(input logic idx, input logic [30:0] val);
		rows.push_back('{ROW_CFG, idx, val, 32'd0, 32'd0, 1'b0, 1'b0, 24'd0, 1'b0});
	endtask

	task automatic add_vtx(input logic [31:0] x, input logic [31:0] y, input logic ps,
			input logic pe, input logic [23:0] rec, input bit lit);
		rows.push_back('{ROW_VTX, 1'b0, 31'd0, x, y, ps, pe, rec, lit});
	endtask

	// configuration only once every point is out and the back end has settled
	task automatic write_reg(input logic idx, input logic [30:0] val);
		while (point_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ENABLE) mdl_en = val[0];
		else mdl_dist = val;
	endtask

	task automatic send_vtx(input logic [31:0] x, input logic [31:0] y, input logic ps,
			input logic pe, input logic [23:0] rec, input bit lit);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {8'h00, rec, y, x};
		s_axis_tuser  <= {pe, ps};
		do @(posedge clk); while (!s_axis_tready);
		n_vtx++;
		densify_vertex(x, y, ps, pe, rec);
		if (lit) point_q.push_back('{x, y, rec, 1'b1, 1'b0});
		else foreach (pt_q[i]) point_q.push_back(pt_q[i]);
	endtask

	// m_axis back-pressure: bursts of stall and of ready
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= $urandom_range(0, 2) != 0;
			stall_left <= $urandom_range(1, 16);
		end
	end

	// compare each point beat with the oldest expectation
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (point_q.size() == 0) begin
				report("unexpected point", 96'(m_axis_tdata), 96'd0);
			end else begin
				want = point_q.pop_front();
				if (m_axis_tdata[31:0] !== want.x)
					report("point_x", 96'(m_axis_tdata[31:0]), 96'(want.x));
				if (m_axis_tdata[63:32] !== want.y)
					report("point_y", 96'(m_axis_tdata[63:32]), 96'(want.y));
				if (m_axis_tdata[87:64] !== want.rec)
					report("point_record", 96'(m_axis_tdata[87:64]), 96'(want.rec));
				if (m_axis_tlast !== want.last)
					report("run_last", 96'(m_axis_tlast), 96'(want.last));
				if (m_axis_tuser[0] !== want.clamp)
					report("count_clamped", 96'(m_axis_tuser), 96'(want.clamp));
			end
			n_points++;
		end
	end

	// watchdog: too long with no beat anywhere
	int idle_cyc = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cyc <= 0;
		end else if (idle_cyc == WD_LIMIT) begin
			$display("polyline_densify regression: fail");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	initial begin
		logic [31:0] x, y;
		logic [30:0] d;
		logic [23:0] rec;
		int len;
		mdl_en = 1'b0;
		mdl_dist = DIST_RESET;
		mdl_px = '0;
		mdl_py = '0;
		mdl_have = 1'b0;

		// directed: copy mode after reset, field extremes pass straight through
		add_vtx(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 24'h000000, 1'b1);
		add_vtx(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, 24'hffffff, 1'b1);
		add_vtx(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1, 24'h5a5a5a, 1'b1);
		add_vtx(32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 24'ha5a5a5, 1'b1);
		// densify at the reset spacing of 100.0
		add_cfg(REG_ENABLE, 31'd1);
		add_vtx(32'd0, 32'd0, 1'b1, 1'b0, 24'd1, 1'b0);        // opens part, no point
		add_vtx(32'd76800, 32'd0, 1'b0, 1'b0, 24'd1, 1'b0);    // exactly 3 spacings
		add_vtx(32'd76800, 32'd25599, 1'b0, 1'b0, 24'd1, 1'b0); // just short of one
		add_vtx(-32'sd51200, 32'd1000, 1'b0, 1'b1, 24'd1, 1'b0); // part end, vertex out
		add_vtx(32'd300, 32'd300, 1'b1, 1'b1, 24'd2, 1'b0);    // lone vertex part
		add_vtx(32'd0, 32'd0, 1'b1, 1'b0, 24'd3, 1'b0);
		add_vtx(32'd5, 32'd5, 1'b1, 1'b0, 24'd3, 1'b0);        // restart, part dropped
		add_vtx(32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0, 24'd3, 1'b0); // saturates
		add_vtx(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 24'd3, 1'b0); // widest span
		add_vtx(32'd10, 32'd10, 1'b0, 1'b0, 24'd4, 1'b0);      // no open part
		add_vtx(32'd10, 32'd10, 1'b0, 1'b0, 24'd4, 1'b0);      // zero-length segment
		add_cfg(REG_DISTANCE, 31'd0);                          // zero spacing copies
		add_vtx(32'd20, -32'sd20, 1'b0, 1'b0, 24'd5, 1'b0);
		add_cfg(REG_DISTANCE, 31'h7fff_ffff);                  // widest spacing
		add_vtx(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0, 24'd6, 1'b0);
		add_vtx(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1, 24'd6, 1'b0);
		add_cfg(REG_DISTANCE, 31'd1);                          // finest spacing
		add_vtx(32'd0, 32'd0, 1'b1, 1'b0, 24'd7, 1'b0);
		add_vtx(32'd40, -32'sd30, 1'b0, 1'b1, 24'd7, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				s_axis_tvalid <= 1'b0;
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_vtx(rows[i].x, rows[i].y, rows[i].ps, rows[i].pe, rows[i].rec,
					rows[i].lit);
			end
		end

		// random phases, each under its own setting; the last with no idling
		for (int ph = 0; ph < 8; ph++) begin
			s_axis_tvalid <= 1'b0;
			write_reg(REG_ENABLE, 31'($urandom_range(0, 5) != 0));
			case ($urandom_range(0, 5))
				0: d = 31'd0;
				1: d = 31'h7fff_ffff;
				2: d = 31'($urandom);
				default: d = 31'($urandom_range(64, 25600));
			endcase
			write_reg(REG_DISTANCE, d);
			quiet = (ph == 7);
			for (int k = 0; k < 36; ) begin
				rec = 24'($urandom);
				if ($urandom_range(0, 4) == 0) begin
					// noise: any coordinate, any marks
					send_vtx($urandom, $urandom, 1'($urandom), 1'($urandom), rec, 1'b0);
					k++;
				end else begin
					// one part of 1 to 6 vertices, steps of a few spacings
					x = $urandom;
					y = $urandom;
					len = $urandom_range(1, 6);
					for (int v = 0; v < len; v++) begin
						if (v > 0) begin
							x = x + 32'($signed($urandom_range(0, 8 * d + 64)) - 4 * d - 32);
							y = y + 32'($signed($urandom_range(0, 8 * d + 64)) - 4 * d - 32);
						end
						// a broken part now and then: missing end or start
						send_vtx(x, y, v == 0 && $urandom_range(0, 9) != 0,
							v == len - 1 && $urandom_range(0, 9) != 0, rec, 1'b0);
						k++;
					end
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (point_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("checked %0d points from %0d vertices, %0d saturated segments",
			n_points, n_vtx, n_clamped);
		if (errors == 0) begin
			$display("polyline_densify regression: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("polyline_densify regression: fail");
		end
		$finish;
	end

endmodule
